// File: src/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared types and widths for the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int unsigned AW = 30;   // normalized cross magnitude
  localparam int unsigned SW = 62;   // sum of squares
  localparam int unsigned RW = 31;   // integer square root
  localparam int unsigned NW = 46;   // division remainder
  localparam int unsigned DW = 32;   // divisor 2r
  localparam int unsigned QW = 15;   // quotient magnitude

  // Side data that rides along with every request.
  typedef struct packed {
    logic       vld;
    logic [2:0] neg;
    logic       deg;
    logic       fin;
  } side_t;

  typedef logic [2:0][AW-1:0] mag_t;
  typedef logic [2:0][NW-1:0] drem_t;
  typedef logic [2:0][QW-1:0] quot_t;

endpackage

// File: src/tfn_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tfn_sqrt_cell
// One bit of a restoring integer square root, registered.
// ----------------------------------------------------------------------------
module tfn_sqrt_cell #(
  parameter int unsigned BITPOS = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [tfn_pkg::SW-1:0]    rem_in,
  input  logic [tfn_pkg::RW-1:0]    root_in,
  input  tfn_pkg::mag_t             a_in,
  input  tfn_pkg::side_t            side_in,
  output logic [tfn_pkg::SW-1:0]    rem,
  output logic [tfn_pkg::RW-1:0]    root,
  output tfn_pkg::mag_t             a,
  output tfn_pkg::side_t            side
);
  import tfn_pkg::*;

  logic [63:0] term;
  logic        take;

  // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b)
  always_comb begin
    term = (64'(root_in) << (BITPOS + 1)) + (64'd1 << (2 * BITPOS));
    take = {2'b00, rem_in} >= term;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side.vld <= 1'b0;
    end else if (en) begin
      side.vld <= side_in.vld;
    end
    if (en) begin
      rem       <= take ? rem_in - term[SW-1:0] : rem_in;
      root      <= take ? root_in | (RW'(1) << BITPOS) : root_in;
      a         <= a_in;
      side.neg  <= side_in.neg;
      side.deg  <= side_in.deg;
      side.fin  <= side_in.fin;
    end
  end

endmodule

// File: src/tfn_div_cell.sv
// ----------------------------------------------------------------------------
// tfn_div_cell
// One quotient bit of three restoring divisions sharing one divisor.
// ----------------------------------------------------------------------------
module tfn_div_cell #(
  parameter int unsigned BITPOS = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  tfn_pkg::drem_t         rem_in,
  input  tfn_pkg::quot_t         q_in,
  input  logic [tfn_pkg::DW-1:0] d_in,
  input  tfn_pkg::side_t         side_in,
  output tfn_pkg::drem_t         rem,
  output tfn_pkg::quot_t         q,
  output logic [tfn_pkg::DW-1:0] d,
  output tfn_pkg::side_t         side
);
  import tfn_pkg::*;

  logic [NW-1:0] dsh;
  drem_t         rem_next;
  quot_t         q_next;

  always_comb begin
    dsh = NW'(d_in) << BITPOS;
    for (int i = 0; i < 3; i++) begin
      if (rem_in[i] >= dsh) begin
        rem_next[i] = rem_in[i] - dsh;
        q_next[i]   = q_in[i] | (QW'(1) << BITPOS);
      end else begin
        rem_next[i] = rem_in[i];
        q_next[i]   = q_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side.vld <= 1'b0;
    end else if (en) begin
      side.vld <= side_in.vld;
    end
    if (en) begin
      rem      <= rem_next;
      q        <= q_next;
      d        <= d_in;
      side.neg <= side_in.neg;
      side.deg <= side_in.deg;
      side.fin <= side_in.fin;
    end
  end

endmodule

// File: src/triangle_face_normal.sv
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of a triangle, Q4.12 corners in, Q1.14 normal out.
// ----------------------------------------------------------------------------
// Fully pipelined: one triangle per clock while the output is not stalled.
// Eight front stages form edges, cross product, magnitude, normalizing shift
// and sum of squares; a row of 31 square-root cells (one root bit each) and
// a row of 15 division cells (one quotient bit each) follow, then the output
// register. The whole pipe advances when the output register is empty or
// taken, so a stalled output holds every stage. A zero cross product gives
// a zero normal with degenerate set.
module triangle_face_normal (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] first_x,
  input  logic [15:0] first_y,
  input  logic [15:0] first_z,
  input  logic [15:0] second_x,
  input  logic [15:0] second_y,
  input  logic [15:0] second_z,
  input  logic [15:0] third_x,
  input  logic [15:0] third_y,
  input  logic [15:0] third_z,
  input  logic        final_triangle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] normal_x,
  output logic [15:0] normal_y,
  output logic [15:0] normal_z,
  output logic        degenerate,
  output logic        final_normal
);
  import tfn_pkg::*;

  logic en;
  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  // stage valids, front section
  logic [8:1] v;
  logic [8:1] fin;

  logic signed [16:0] e1 [3];
  logic signed [16:0] e2 [3];
  logic signed [33:0] pr [6];
  logic [2:0][33:0]   mag;
  logic [2:0]         neg3;
  logic [2:0][33:0]   mag4;
  logic [2:0]         neg4;
  logic [33:0]        m4;
  logic               deg4;
  logic [2:0][33:0]   mag5;
  logic [2:0]         neg5;
  logic [5:0]         p5;
  logic               deg5;
  mag_t               a6;
  logic [2:0]         neg6;
  logic               deg6;
  logic [2:0][59:0]   sq7;
  mag_t               a7;
  logic [2:0]         neg7;
  logic               deg7;
  logic [SW-1:0]      s8;
  mag_t               a8;
  logic [2:0]         neg8;
  logic               deg8;

  logic signed [34:0] c3 [3];
  logic [33:0]        mmax;
  logic [5:0]         pos;
  logic [63:0]        shv [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c3[i] = {pr[2*i][33], pr[2*i]} - {pr[2*i+1][33], pr[2*i+1]};
    end
    mmax = mag[0];
    if (mag[1] > mmax) mmax = mag[1];
    if (mag[2] > mmax) mmax = mag[2];
    pos = '0;
    for (int b = 0; b < 34; b++) begin
      if (m4[b]) pos = 6'(b);
    end
    for (int i = 0; i < 3; i++) begin
      if (p5 >= 6'd30) shv[i] = {30'd0, mag5[i]} >> (p5 - 6'd29);
      else             shv[i] = {30'd0, mag5[i]} << (6'd29 - p5);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[7:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin <= {fin[7:1], final_triangle};
      // edges
      e1[0] <= {second_x[15], second_x} - {first_x[15], first_x};
      e1[1] <= {second_y[15], second_y} - {first_y[15], first_y};
      e1[2] <= {second_z[15], second_z} - {first_z[15], first_z};
      e2[0] <= {third_x[15], third_x} - {second_x[15], second_x};
      e2[1] <= {third_y[15], third_y} - {second_y[15], second_y};
      e2[2] <= {third_z[15], third_z} - {second_z[15], second_z};
      // cross products
      pr[0] <= e1[1] * e2[2];
      pr[1] <= e1[2] * e2[1];
      pr[2] <= e1[2] * e2[0];
      pr[3] <= e1[0] * e2[2];
      pr[4] <= e1[0] * e2[1];
      pr[5] <= e1[1] * e2[0];
      // magnitudes
      for (int i = 0; i < 3; i++) begin
        neg3[i] <= c3[i][34];
        mag[i]  <= c3[i][34] ? 34'(-c3[i]) : c3[i][33:0];
      end
      // largest magnitude
      mag4 <= mag;
      neg4 <= neg3;
      m4   <= mmax;
      deg4 <= (mmax == '0);
      // leading one position
      mag5 <= mag4;
      neg5 <= neg4;
      p5   <= pos;
      deg5 <= deg4;
      // common normalizing shift
      for (int i = 0; i < 3; i++) a6[i] <= shv[i][AW-1:0];
      neg6 <= neg5;
      deg6 <= deg5;
      // squares
      for (int i = 0; i < 3; i++) sq7[i] <= a6[i] * a6[i];
      a7   <= a6;
      neg7 <= neg6;
      deg7 <= deg6;
      // sum of squares
      s8   <= SW'(sq7[0]) + SW'(sq7[1]) + SW'(sq7[2]);
      a8   <= a7;
      neg8 <= neg7;
      deg8 <= deg7;
    end
  end

  // square root row
  logic [SW-1:0] srem  [RW+1];
  logic [RW-1:0] sroot [RW+1];
  mag_t          sa    [RW+1];
  side_t         sside [RW+1];

  assign srem[0]  = s8;
  assign sroot[0] = '0;
  assign sa[0]    = a8;
  assign sside[0] = '{vld: v[8], neg: neg8, deg: deg8, fin: fin[8]};

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    tfn_sqrt_cell #(.BITPOS(RW - 1 - k)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .rem_in  (srem[k]),
      .root_in (sroot[k]),
      .a_in    (sa[k]),
      .side_in (sside[k]),
      .rem     (srem[k+1]),
      .root    (sroot[k+1]),
      .a       (sa[k+1]),
      .side    (sside[k+1])
    );
  end

  // division row: q = floor((a * 2^15 + r) / 2r)
  drem_t         drem  [QW+1];
  quot_t         dq    [QW+1];
  logic [DW-1:0] dd    [QW+1];
  side_t         dside [QW+1];

  assign drem[0]  = {{1'b0, sa[RW][2], 15'd0} + NW'(sroot[RW]),
                     {1'b0, sa[RW][1], 15'd0} + NW'(sroot[RW]),
                     {1'b0, sa[RW][0], 15'd0} + NW'(sroot[RW])};
  assign dq[0]    = '0;
  assign dd[0]    = {sroot[RW], 1'b0};
  assign dside[0] = sside[RW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    tfn_div_cell #(.BITPOS(QW - 1 - k)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .rem_in  (drem[k]),
      .q_in    (dq[k]),
      .d_in    (dd[k]),
      .side_in (dside[k]),
      .rem     (drem[k+1]),
      .q       (dq[k+1]),
      .d       (dd[k+1]),
      .side    (dside[k+1])
    );
  end

  logic [2:0][15:0] nv;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dside[QW].deg)      nv[i] = '0;
      else if (dside[QW].neg[i]) nv[i] = 16'(-{1'b0, dq[QW][i]});
      else                    nv[i] = {1'b0, dq[QW][i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dside[QW].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      normal_x     <= nv[0];
      normal_y     <= nv[1];
      normal_z     <= nv[2];
      degenerate   <= dside[QW].deg;
      final_normal <= dside[QW].fin;
    end
  end

endmodule
